// ===== rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

	// Field widths fixed by the pixel formats.
	localparam int HUE_W = 13;
	localparam int PCT_W = 7;
	localparam int CH_W  = 8;

	// Largest legal saturation and brightness, in percent.
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

	// Width of 255 * brightness (at most 25500).
	localparam int V255_W = 15;

	// Width of 255 * brightness * (100 - saturation) (at most 2550000).
	localparam int ZN_W = 22;

	// Width of the secondary numerator after the hue fraction is shifted out.
	localparam int XM_W = 28;

	// Constant divisors of the three channel levels.
	localparam int FULL_DIV = 100;
	localparam int ZERO_DIV = 10000;
	localparam int X_DIV    = 600000;

	// Reciprocals floor(2^K / divisor); K equals the dividend width, so the
	// estimate is the true quotient or one below it.
	localparam logic [8:0] FULL_REC = 9'd327;
	localparam int         FULL_SH  = 15;
	localparam logic [8:0] ZERO_REC = 9'd419;
	localparam int         ZERO_SH  = 22;
	localparam logic [8:0] X_REC    = 9'd447;
	localparam int         X_SH     = 28;

	// Input word: one HSV pixel.
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] brightness;
	} hsv_t;

	// Output word: one RGB pixel.
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            in_range;
	} rgb_t;

endpackage

// ===== rtl/hsv_to_rgb_converter_core.sv =====
// Channel  Ports              Handshake
// -------  -----------------  ------------------------------------------
// input    hsv                taken when start is high and busy is low
// output   rgb                valid for one cycle while done is high
//
// A word passes through five register stages, and its RGB word appears with done
// at the output of the last of them. A new word may enter at every clock. The
// channel arithmetic sets the depth: two chained multiplies, then reciprocal
// estimates and their corrections, each behind a register.
// busy stays low, since the pipeline never holds off. The result cannot stall.
// Reset clears the stage valid bits only; no pixel is in flight afterward.
module hsv_to_rgb_converter_core #(
	parameter int HUE_FRAC_BITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  hsv2rgb_pkg::hsv_t  hsv,
	output logic               done,
	output hsv2rgb_pkg::rgb_t  rgb
);

	import hsv2rgb_pkg::*;

	// Hue constants in hue units.
	localparam int SIXTY   = 60 << HUE_FRAC_BITS;
	localparam int HUE_TOP = 360 << HUE_FRAC_BITS;
	localparam int DIST_W  = $clog2(SIXTY + 1);
	localparam int T_W     = $clog2(100 * SIXTY + 1);
	localparam int SD_W    = PCT_W + DIST_W;
	localparam int N_W     = V255_W + T_W;

	// Widths of the reciprocal products.
	localparam int FP_W = V255_W + 9;
	localparam int ZP_W = ZN_W + 9;
	localparam int XP_W = XM_W + 9;

	// The pipeline takes a word every cycle.
	assign busy = 1'b0;

	logic take;
	assign take = start & ~busy;

	// Stage valid bits.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Stage 1: range check, hue sector, distance from the middle of its 120-degree span and 255 * brightness.
	logic [31:0]        hue_c;
	logic [2:0]         sec_c;
	logic [31:0]        base_c;
	logic [31:0]        hm_c;
	logic [DIST_W-1:0]  dist_c;
	logic               ok_c;

	assign hue_c = 32'(hsv.hue);
	assign ok_c  = (hue_c <= 32'(HUE_TOP)) && (hsv.saturation <= PCT_MAX)
		&& (hsv.brightness <= PCT_MAX);

	always_comb begin
		sec_c = 3'd0;
		for (int k = 1; k <= 5; k++) begin
			if (hue_c >= 32'(k * SIXTY)) begin
				sec_c = 3'(k);
			end
		end
	end

	// Start of the 120-degree span that holds the hue.
	always_comb begin
		unique case (sec_c)
			3'd0, 3'd1: base_c = 32'd0;
			3'd2, 3'd3: base_c = 32'(2 * SIXTY);
			default:    base_c = 32'(4 * SIXTY);
		endcase
	end

	assign hm_c   = hue_c - base_c;
	assign dist_c = (hm_c >= 32'(SIXTY)) ? DIST_W'(hm_c - 32'(SIXTY))
		: DIST_W'(32'(SIXTY) - hm_c);

	logic [2:0]         sec_s1;
	logic               ok_s1;
	logic [DIST_W-1:0]  dist_s1;
	logic [PCT_W-1:0]   sat_s1;
	logic [V255_W-1:0]  v255_s1;

	always_ff @(posedge clk) begin
		sec_s1  <= sec_c;
		ok_s1   <= ok_c;
		dist_s1 <= dist_c;
		sat_s1  <= hsv.saturation;
		v255_s1 <= (V255_W'(hsv.brightness) << 8) - V255_W'(hsv.brightness);
	end

	// Stage 2: secondary weight 100*D - S*dist and the zero-level numerator.
	logic [SD_W-1:0]   sd_c;
	logic [T_W-1:0]    t_c;
	logic [PCT_W-1:0]  sc_c;
	logic [ZN_W-1:0]   zn_c;

	assign sd_c = SD_W'(sat_s1) * SD_W'(dist_s1);
	assign t_c  = T_W'(100 * SIXTY) - T_W'(sd_c);
	assign sc_c = PCT_MAX - sat_s1;
	assign zn_c = ZN_W'(v255_s1) * ZN_W'(sc_c);

	logic [2:0]         sec_s2;
	logic               ok_s2;
	logic [V255_W-1:0]  v255_s2;
	logic [T_W-1:0]     t_s2;
	logic [ZN_W-1:0]    zn_s2;

	always_ff @(posedge clk) begin
		sec_s2  <= sec_s1;
		ok_s2   <= ok_s1;
		v255_s2 <= v255_s1;
		t_s2    <= t_c;
		zn_s2   <= zn_c;
	end

	// Stage 3: secondary numerator and reciprocal estimates of the other levels.
	logic [N_W-1:0]             n_c;
	logic [FP_W-1:0]            fp_c;
	logic [ZP_W-1:0]            zp_c;

	assign n_c  = N_W'(v255_s2) * N_W'(t_s2);
	assign fp_c = FP_W'(v255_s2) * FP_W'(FULL_REC);
	assign zp_c = ZP_W'(zn_s2) * ZP_W'(ZERO_REC);

	logic [2:0]         sec_s3;
	logic               ok_s3;
	logic [V255_W-1:0]  v255_s3;
	logic [ZN_W-1:0]    zn_s3;
	logic [XM_W-1:0]    m_s3;
	logic [CH_W-1:0]    fe_s3;
	logic [CH_W-1:0]    ze_s3;

	always_ff @(posedge clk) begin
		sec_s3  <= sec_s2;
		ok_s3   <= ok_s2;
		v255_s3 <= v255_s2;
		zn_s3   <= zn_s2;
		m_s3    <= XM_W'(n_c >> HUE_FRAC_BITS);
		fe_s3   <= fp_c[FULL_SH +: CH_W];
		ze_s3   <= zp_c[ZERO_SH +: CH_W];
	end

	// Stage 4: correct the full and zero levels, estimate the secondary level.
	logic [V255_W-1:0]   fm_c;
	logic [V255_W-1:0]   fr_c;
	logic [ZN_W-1:0]     zm_c;
	logic [ZN_W-1:0]     zr_c;
	logic [XP_W-1:0]     xp_c;

	assign fm_c = V255_W'(fe_s3) * V255_W'(FULL_DIV);
	assign fr_c = v255_s3 - fm_c;
	assign zm_c = ZN_W'(ze_s3) * ZN_W'(ZERO_DIV);
	assign zr_c = zn_s3 - zm_c;
	assign xp_c = XP_W'(m_s3) * XP_W'(X_REC);

	logic [2:0]       sec_s4;
	logic             ok_s4;
	logic [XM_W-1:0]  m_s4;
	logic [CH_W-1:0]  full_s4;
	logic [CH_W-1:0]  zero_s4;
	logic [CH_W-1:0]  xe_s4;

	always_ff @(posedge clk) begin
		sec_s4  <= sec_s3;
		ok_s4   <= ok_s3;
		m_s4    <= m_s3;
		full_s4 <= fe_s3 + CH_W'(fr_c >= V255_W'(FULL_DIV));
		zero_s4 <= ze_s3 + CH_W'(zr_c >= ZN_W'(ZERO_DIV));
		xe_s4   <= xp_c[X_SH +: CH_W];
	end

	// Stage 5: correct the secondary level and route the levels by sector.
	logic [XM_W-1:0]  xm_c;
	logic [XM_W-1:0]  xr_c;
	logic [CH_W-1:0]  x_c;
	rgb_t             pix_c;

	assign xm_c = XM_W'(xe_s4) * XM_W'(X_DIV);
	assign xr_c = m_s4 - xm_c;
	assign x_c  = xe_s4 + CH_W'(xr_c >= XM_W'(X_DIV));

	always_comb begin
		pix_c.in_range = ok_s4;
		unique case (sec_s4)
			3'd0: begin
				pix_c.red = full_s4; pix_c.green = x_c;     pix_c.blue = zero_s4;
			end
			3'd1: begin
				pix_c.red = x_c;     pix_c.green = full_s4; pix_c.blue = zero_s4;
			end
			3'd2: begin
				pix_c.red = zero_s4; pix_c.green = full_s4; pix_c.blue = x_c;
			end
			3'd3: begin
				pix_c.red = zero_s4; pix_c.green = x_c;     pix_c.blue = full_s4;
			end
			3'd4: begin
				pix_c.red = x_c;     pix_c.green = zero_s4; pix_c.blue = full_s4;
			end
			default: begin
				pix_c.red = full_s4; pix_c.green = zero_s4; pix_c.blue = x_c;
			end
		endcase
		// Out-of-range pixels come out black.
		if (!ok_s4) begin
			pix_c.red   = '0;
			pix_c.green = '0;
			pix_c.blue  = '0;
		end
	end

	rgb_t pix_s5;

	always_ff @(posedge clk) begin
		pix_s5 <= pix_c;
	end

	assign done = valid_s5;
	assign rgb  = pix_s5;

endmodule

// ===== sim/hsv_to_rgb_converter_core_tb.sv =====
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core_tb;
	import hsv2rgb_pkg::*;

	localparam int HUE_FRAC_BITS = 4;
	localparam int CLK_HALF_NS   = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int DRAIN_CYCLES  = 12;
	localparam int RANDOM_WORDS  = 800;
	localparam int STEADY_WORDS  = 200;
	localparam int STRETCH_WORDS = 40;

	// Hue scale in fixed-point units.
	localparam longint unsigned HUE_SIXTY = 64'd60 << HUE_FRAC_BITS;
	localparam longint unsigned HUE_FULL  = 64'd360 << HUE_FRAC_BITS;

	// The six 60-degree hue sectors, named by the colors at their ends.
	typedef enum int {
		SEC_RED_YELLOW,
		SEC_YELLOW_GREEN,
		SEC_GREEN_CYAN,
		SEC_CYAN_BLUE,
		SEC_BLUE_MAGENTA,
		SEC_MAGENTA_RED
	} hue_sector_t;

	// A word in flight together with the RGB word it must produce.
	typedef struct {
		hsv_t px;
		rgb_t want;
	} pixel_in_flight_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	hsv_t hsv    = '0;
	logic busy;
	logic done;
	rgb_t rgb;

	pixel_in_flight_t rgb_pending[$];
	int unsigned      mismatch_count = 0;
	bit               sender_idles   = 1'b1;

	hsv_to_rgb_converter_core #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.hsv   (hsv),
		.done  (done),
		.rgb   (rgb)
	);

	// Free-running clock.
	always begin
		#CLK_HALF_NS clk = 1'b1;
		#CLK_HALF_NS clk = 1'b0;
	end

	// Exact integer HSV to RGB conversion, floored once at the end.
	function automatic rgb_t convert_hsv(hsv_t px);
		longint unsigned h;
		longint unsigned s;
		longint unsigned v;
		longint unsigned hue_mod;
		longint unsigned hue_dist;
		longint unsigned lvl_full;
		longint unsigned lvl_zero;
		longint unsigned lvl_x;
		hue_sector_t     sector;
		rgb_t            res;

		h   = 64'(px.hue);
		s   = 64'(px.saturation);
		v   = 64'(px.brightness);
		res = '0;
		if (h > HUE_FULL || s > PCT_MAX || v > PCT_MAX) begin
			return res;
		end

		hue_mod  = h % (2 * HUE_SIXTY);
		hue_dist = (hue_mod >= HUE_SIXTY) ? (hue_mod - HUE_SIXTY) : (HUE_SIXTY - hue_mod);
		lvl_full = (255 * v) / 100;
		lvl_zero = (255 * v * (100 - s)) / 10000;
		lvl_x    = (255 * v * (s * (HUE_SIXTY - hue_dist) + (100 - s) * HUE_SIXTY))
			/ (10000 * HUE_SIXTY);

		// Hue of exactly 360 degrees lands past the last sector and shares its mapping.
		sector = hue_sector_t'(int'(h / HUE_SIXTY));
		case (sector)
			SEC_RED_YELLOW: begin
				res.red = lvl_full[7:0]; res.green = lvl_x[7:0];    res.blue = lvl_zero[7:0];
			end
			SEC_YELLOW_GREEN: begin
				res.red = lvl_x[7:0];    res.green = lvl_full[7:0]; res.blue = lvl_zero[7:0];
			end
			SEC_GREEN_CYAN: begin
				res.red = lvl_zero[7:0]; res.green = lvl_full[7:0]; res.blue = lvl_x[7:0];
			end
			SEC_CYAN_BLUE: begin
				res.red = lvl_zero[7:0]; res.green = lvl_x[7:0];    res.blue = lvl_full[7:0];
			end
			SEC_BLUE_MAGENTA: begin
				res.red = lvl_x[7:0];    res.green = lvl_zero[7:0]; res.blue = lvl_full[7:0];
			end
			default: begin
				res.red = lvl_full[7:0]; res.green = lvl_zero[7:0]; res.blue = lvl_x[7:0];
			end
		endcase
		res.in_range = 1'b1;
		return res;
	endfunction

	// One line per mismatch, and a running count.
	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("%0t ERROR %s", $realtime, what);
	endtask

	// Text for a field that differs, with the pixel that caused it.
	function automatic string field_note(string what, hsv_t px, int got, int want);
		return $sformatf("%s: hue=%0d sat=%0d val=%0d got %0d want %0d",
			what, px.hue, px.saturation, px.brightness, got, want);
	endfunction

	// Offers one word and returns at the edge that takes it; start stays high.
	task automatic send_pixel(logic [HUE_W-1:0] h, logic [PCT_W-1:0] s, logic [PCT_W-1:0] v);
		hsv_t px;

		px.hue        = h;
		px.saturation = s;
		px.brightness = v;
		hsv   <= px;
		start <= 1'b1;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		rgb_pending.push_back('{px: px, want: convert_hsv(px)});
	endtask

	// Random burst of idle cycles on the input side, when idling is enabled.
	task automatic sender_gap();
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_and_gap(int h, int s, int v);
		send_pixel(HUE_W'(h), PCT_W'(s), PCT_W'(v));
		sender_gap();
	endtask

	// Each result word is compared with the oldest word still in flight.
	always @(posedge clk) begin
		pixel_in_flight_t head;

		if (arst_n && done === 1'b1) begin
			if (rgb_pending.size() == 0) begin
				report_mismatch("result word with nothing in flight");
			end else begin
				head = rgb_pending.pop_front();
				if (rgb.red !== head.want.red)
					report_mismatch(field_note("red", head.px, int'(rgb.red),
						int'(head.want.red)));
				if (rgb.green !== head.want.green)
					report_mismatch(field_note("green", head.px, int'(rgb.green),
						int'(head.want.green)));
				if (rgb.blue !== head.want.blue)
					report_mismatch(field_note("blue", head.px, int'(rgb.blue),
						int'(head.want.blue)));
				if (rgb.in_range !== head.want.in_range)
					report_mismatch(field_note("in_range", head.px, int'(rgb.in_range),
						int'(head.want.in_range)));
			end
		end
	end

	// Primaries, secondaries and the hue sector edges at full color.
	task automatic test_sector_edges();
		send_and_gap(0, 100, 100);
		send_and_gap(959, 100, 100);
		send_and_gap(960, 100, 100);
		send_and_gap(1920, 100, 100);
		send_and_gap(2880, 100, 100);
		send_and_gap(3840, 100, 100);
		send_and_gap(4800, 100, 100);
		send_and_gap(5759, 100, 100);
		// Hue of exactly 360 degrees must look like hue 0.
		send_and_gap(5760, 100, 100);
	endtask

	// Black, white, grays and the smallest nonzero fields.
	task automatic test_field_extremes();
		send_and_gap(0, 0, 0);
		send_and_gap(0, 0, 100);
		send_and_gap(3000, 0, 57);
		send_and_gap(1, 1, 1);
		send_and_gap(480, 50, 73);
		send_and_gap(5760, 100, 0);
	endtask

	// Any field past its legal range gives black with in_range low; one legal pixel is mixed in.
	task automatic test_out_of_range();
		send_and_gap(5761, 0, 0);
		send_and_gap(8191, 127, 127);
		send_and_gap(0, 101, 50);
		send_and_gap(0, 50, 101);
		send_and_gap(100, 127, 0);
		send_and_gap(4096, 64, 64);
	endtask

	// Mostly legal pixels, some pinned to sector edges, and some raw noise.
	task automatic send_random_pixel();
		int pick;
		int h;
		int s;
		int v;

		pick = $urandom_range(0, 99);
		s    = $urandom_range(0, 100);
		v    = $urandom_range(0, 100);
		if (pick < 10) begin
			h = $urandom_range(0, 8191);
			s = $urandom_range(0, 127);
			v = $urandom_range(0, 127);
		end else if (pick < 30) begin
			h = int'($urandom_range(0, 6)) * int'(HUE_SIXTY)
				+ int'($urandom_range(0, 2)) - 1;
			if (h < 0)
				h = 0;
			if (h > int'(HUE_FULL))
				h = int'(HUE_FULL);
			if ($urandom_range(0, 3) == 0)
				s = 100;
			if ($urandom_range(0, 3) == 0)
				v = 100;
		end else begin
			h = $urandom_range(0, int'(HUE_FULL));
		end
		send_and_gap(h, s, v);
	endtask

	// Random pixels with idling switched on and off in stretches.
	task automatic test_random_pixels();
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % STRETCH_WORDS == 0)
				sender_idles = $urandom_range(0, 2) != 0;
			send_random_pixel();
		end
	endtask

	// A word on every clock until the end.
	task automatic test_back_to_back();
		sender_idles = 1'b0;
		for (int i = 0; i < STEADY_WORDS; i++) begin
			send_random_pixel();
		end
	endtask

	// Sequence of tests and the final verdict.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sector_edges();
		test_field_extremes();
		test_out_of_range();
		test_random_pixels();
		test_back_to_back();

		start <= 1'b0;
		while (rgb_pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("hsv_to_rgb_converter_core regression: pass");
		end else begin
			$display("hsv_to_rgb_converter_core regression: fail");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("%0t ERROR timeout", $realtime);
		$display("hsv_to_rgb_converter_core regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv_to_rgb_converter_core.sv
sim/hsv_to_rgb_converter_core_tb.sv
